@@ design/assert_macros.svh @@
// Assertion macros shared by the frame synchronizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RFSC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rfsc assertion failed");
`define RFSC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rfsc assertion failed");
`else
`define RFSC_ASSERT_IMP(label, clk, rst, ante, cons)
`define RFSC_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

@@ design/rfsc_pkg.sv @@
// Types, constants and the CRC-24Q byte update for the frame synchronizer.
package rfsc_pkg;

   localparam logic [23:0] CRC_POLY      = 24'h864CFB;
   localparam logic [7:0]  PREAMBLE_RST  = 8'hD3;
   localparam int          IDX_W         = 11;
   localparam int          LEN_W         = 10;
   // Header and message bytes are covered by the CRC; the frame ends five past the length.
   localparam logic [IDX_W-1:0] COVER_OFS = 11'd3;
   localparam logic [IDX_W-1:0] END_OFS   = 11'd5;
   localparam logic [IDX_W-1:0] IDX_LEN_HI = 11'd1;
   localparam logic [IDX_W-1:0] IDX_LEN_LO = 11'd2;

   localparam logic [2:0] STATUS_IGNORED  = 3'd0;
   localparam logic [2:0] STATUS_START    = 3'd1;
   localparam logic [2:0] STATUS_IN_FRAME = 3'd2;
   localparam logic [2:0] STATUS_GOOD     = 3'd3;
   localparam logic [2:0] STATUS_BAD      = 3'd4;

   typedef struct packed {
      logic [7:0]       data_byte;
      logic [IDX_W-1:0] byte_index;
      logic [2:0]       frame_status;
      logic [LEN_W-1:0] msg_length;
      logic             frame_last;
   } rsp_payload_type;

   function automatic logic [23:0] crc24q_byte(input logic [23:0] crc, input logic [7:0] b);
      logic [23:0] c;
      c = crc ^ {b, 16'h0000};
      for (int i = 0; i < 8; i++) begin
         c = c[23] ? ({c[22:0], 1'b0} ^ CRC_POLY) : {c[22:0], 1'b0};
      end
      return c;
   endfunction

endpackage

@@ design/rfsc_if.sv @@
// Request, response and register write channel interfaces.
interface rfsc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source(output valid, output rx_byte, input ready);
   modport sink(input valid, input rx_byte, output ready);
endinterface

interface rfsc_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic [10:0] byte_index;
   logic [2:0]  frame_status;
   logic [9:0]  msg_length;
   logic        frame_last;
   modport source(output valid, output data_byte, output byte_index, output frame_status,
                  output msg_length, output frame_last, input ready);
   modport sink(input valid, input data_byte, input byte_index, input frame_status,
                input msg_length, input frame_last, output ready);
endinterface

interface rfsc_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] wdata;
   modport source(output valid, output wdata, input ready);
   modport sink(input valid, input wdata, output ready);
endinterface

@@ design/rtcm3_frame_sync_crc_check_top.sv @@
// RTCM 3 frame synchronizer with CRC-24Q check. One byte is taken per request and
// one response comes back for each: the byte, its index in the frame, a status, the
// header length and a last-byte flag. Throughput is one byte per clock while the
// response sink keeps up. A byte passes from the input register through the
// tracker, whose combinational path is one byte-wide CRC-24Q update and the length
// compares, into the result register. The preamble register (reset 0xD3) is written
// through the csr channel, which is always ready, and only matters while hunting.
module rtcm3_frame_sync_crc_check_top (
   input logic         clock,
   input logic         reset,
   rfsc_req_if.sink    req_chan,
   rfsc_rsp_if.source  rsp_chan,
   rfsc_csr_if.sink    csr_chan
);
   import rfsc_pkg::*;

   logic            byte_valid;
   logic [7:0]      byte_data;
   logic            can_load;
   logic            load;
   rsp_payload_type result;

   assign load = byte_valid && can_load;

   rfsc_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .advance    (load),
      .byte_valid (byte_valid),
      .byte_data  (byte_data)
   );

   rfsc_frame_track u_track (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .step     (load),
      .rx_byte  (byte_data),
      .result   (result)
   );

   rfsc_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .result   (result),
      .can_load (can_load),
      .rsp_chan (rsp_chan)
   );

`include "assert_macros.svh"

   `RFSC_ASSERT_IMP(a_last_has_verdict, clock, reset, rsp_chan.valid && rsp_chan.frame_last, rsp_chan.frame_status == STATUS_GOOD || rsp_chan.frame_status == STATUS_BAD)
   `RFSC_ASSERT_IMP(a_ignored_at_zero, clock, reset, rsp_chan.valid && rsp_chan.frame_status == STATUS_IGNORED, rsp_chan.byte_index == '0 && !rsp_chan.frame_last)
   `RFSC_ASSERT_IMP(a_in_frame_index, clock, reset, rsp_chan.valid && rsp_chan.frame_status == STATUS_IN_FRAME, rsp_chan.byte_index != '0 && !rsp_chan.frame_last)
   `RFSC_ASSERT_NXT(a_end_reaches_out, clock, reset, load && result.frame_last, rsp_chan.valid && rsp_chan.frame_last)

endmodule

@@ design/rfsc_in_reg.sv @@
// Input register stage: captures one received byte per request.
module rfsc_in_reg (
   input  logic       clock,
   input  logic       reset,
   rfsc_req_if.sink   req_chan,
   input  logic       advance,
   output logic       byte_valid,
   output logic [7:0] byte_data
);
   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       take;

   assign req_chan.ready = !valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = take ? 1'b1 : (advance ? 1'b0 : valid_ff);
      data_in  = take ? req_chan.rx_byte : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign byte_valid = valid_ff;
   assign byte_data  = data_ff;
endmodule

@@ design/rfsc_frame_track.sv @@
// Frame tracker: preamble register, byte count, length, and CRC state.
module rfsc_frame_track (
   input  logic                     clock,
   input  logic                     reset,
   rfsc_csr_if.sink                 csr_chan,
   input  logic                     step,
   input  logic [7:0]               rx_byte,
   output rfsc_pkg::rsp_payload_type result
);
   import rfsc_pkg::*;

   logic [7:0]       preamble_ff, preamble_in;
   logic [IDX_W-1:0] count_ff, count_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [23:0]      crc_run_ff, crc_run_in;
   logic [23:0]      crc_rx_ff, crc_rx_in;

   logic [IDX_W-1:0] len_ext;
   logic             hunting;
   logic             covered;
   logic             frame_end;

   assign csr_chan.ready = 1'b1;
   assign preamble_in    = csr_chan.valid ? csr_chan.wdata : preamble_ff;
   assign hunting        = (count_ff == '0);

   always_comb begin
      len_in     = len_ff;
      crc_run_in = crc_run_ff;
      crc_rx_in  = crc_rx_ff;
      count_in   = count_ff;
      result.data_byte    = rx_byte;
      result.byte_index   = count_ff;
      result.frame_status = STATUS_IGNORED;
      result.msg_length   = '0;
      result.frame_last   = 1'b0;

      // The length is complete only after byte two; compares use the updated value.
      if (count_ff == IDX_LEN_HI) begin
         len_in = {rx_byte[1:0], 8'h00};
      end else if (count_ff == IDX_LEN_LO) begin
         len_in = {len_ff[LEN_W-1:8], rx_byte};
      end
      len_ext   = {1'b0, len_in};
      covered   = (count_ff < len_ext + COVER_OFS) || (count_ff < COVER_OFS);
      frame_end = (count_ff >= END_OFS) && (count_ff >= len_ext + END_OFS);

      if (hunting) begin
         len_in = len_ff;
         if (rx_byte == preamble_ff) begin
            crc_run_in = crc24q_byte(24'h000000, rx_byte);
            crc_rx_in  = '0;
            len_in     = '0;
            count_in   = 11'd1;
            result.frame_status = STATUS_START;
         end
      end else begin
         if (covered) begin
            crc_run_in = crc24q_byte(crc_run_ff, rx_byte);
         end else begin
            crc_rx_in = {crc_rx_ff[15:0], rx_byte};
         end
         if (count_ff >= IDX_LEN_LO) begin
            result.msg_length = len_in;
         end
         if (frame_end) begin
            result.frame_status = (crc_run_in == crc_rx_in) ? STATUS_GOOD : STATUS_BAD;
            result.frame_last   = 1'b1;
            count_in            = '0;
         end else begin
            result.frame_status = STATUS_IN_FRAME;
            count_in            = count_ff + 11'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         preamble_ff <= PREAMBLE_RST;
         count_ff    <= '0;
         len_ff      <= '0;
         crc_run_ff  <= '0;
         crc_rx_ff   <= '0;
      end else begin
         preamble_ff <= preamble_in;
         if (step) begin
            count_ff   <= count_in;
            len_ff     <= len_in;
            crc_run_ff <= crc_run_in;
            crc_rx_ff  <= crc_rx_in;
         end
      end
   end
endmodule

@@ design/rfsc_out_reg.sv @@
// Result register: holds one response until the sink takes it.
module rfsc_out_reg (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  rfsc_pkg::rsp_payload_type result,
   output logic                     can_load,
   rfsc_rsp_if.source               rsp_chan
);
   import rfsc_pkg::*;

   logic            valid_ff, valid_in;
   rsp_payload_type data_ff, data_in;

   assign can_load = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = load ? 1'b1 : (rsp_chan.ready ? 1'b0 : valid_ff);
      data_in  = load ? result : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_chan.valid        = valid_ff;
   assign rsp_chan.data_byte    = data_ff.data_byte;
   assign rsp_chan.byte_index   = data_ff.byte_index;
   assign rsp_chan.frame_status = data_ff.frame_status;
   assign rsp_chan.msg_length   = data_ff.msg_length;
   assign rsp_chan.frame_last   = data_ff.frame_last;
endmodule
